// ===== rtl/sce_pkg.sv =====
// Shared constants and types of the strip cluster eta block.
`timescale 1ns / 1ps
`default_nettype none
package sce_pkg;

    localparam int LADDER_CHANNELS = 384;
    localparam int CH_W            = 9;
    localparam logic [CH_W-1:0] CH_LAST = CH_W'(LADDER_CHANNELS - 1);

    localparam int CNT_W  = 16;
    localparam int SIG_W  = 16;
    localparam int THR_W  = 16;
    localparam int SUM_W  = 18;
    localparam int SN_W   = 24;
    localparam int SNQ_W  = 29;
    localparam int SNS_W  = 31;
    localparam int Q_W    = 18;

    // Restoring divider geometry: dividend must stay below divisor << DIV_QW.
    localparam int DIV_QW = 28;
    localparam int DIV_DW = 18;
    localparam int DIV_NW = 34;

    localparam int PIPE_DEPTH = 3 + DIV_QW;

    localparam logic [Q_W-1:0] Q16_MAX = Q_W'(131072);
    localparam logic signed [SN_W-1:0] SN_MAX = 24'sh7FFFFF;
    localparam logic signed [SN_W-1:0] SN_MIN = 24'sh800000;

    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 16;
    localparam logic [CFG_IDX_W-1:0] REG_SIDE_THRESHOLD = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ETA_MODE       = 1'd1;
    localparam logic [THR_W-1:0]     THR_RESET          = 16'd768;

    typedef struct packed {
        logic signed [CNT_W-1:0] cnt;
        logic signed [CNT_W-1:0] snc;
        logic [SIG_W-1:0]        sns;
        logic                    above;
    } sce_lane_t;

    typedef struct packed {
        logic                    mode;
        logic                    partner_left;
        logic signed [SUM_W-1:0] den;
        logic                    eta_ok;
        logic                    eta_sat;
        logic [1:0]              size;
        logic signed [SUM_W-1:0] above_sum;
        logic                    ctr_ok;
        logic                    ctr_sat;
    } sce_side_t;

endpackage
`default_nettype wire

// ===== rtl/sce_if.sv =====
// Channel interfaces: cluster input, result output and register writes.
`timescale 1ns / 1ps
`default_nettype none
interface sce_cluster_if;
    logic                                 valid;
    logic                                 ready;
    logic [sce_pkg::CH_W-1:0]             ladder_channel;
    logic signed [sce_pkg::CNT_W-1:0]     count_left;
    logic signed [sce_pkg::CNT_W-1:0]     count_seed;
    logic signed [sce_pkg::CNT_W-1:0]     count_right;
    logic [sce_pkg::SIG_W-1:0]            sigma_left;
    logic [sce_pkg::SIG_W-1:0]            sigma_seed;
    logic [sce_pkg::SIG_W-1:0]            sigma_right;

    modport source (output valid, ladder_channel, count_left, count_seed, count_right,
                    sigma_left, sigma_seed, sigma_right, input ready);
    modport sink (input valid, ladder_channel, count_left, count_seed, count_right,
                  sigma_left, sigma_seed, sigma_right, output ready);
endinterface

interface sce_result_if;
    logic                              valid;
    logic                              ready;
    logic [sce_pkg::Q_W-1:0]           eta_value;
    logic signed [sce_pkg::SUM_W-1:0]  eta_counts;
    logic signed [sce_pkg::SN_W-1:0]   eta_sn;
    logic                              eta_invalid;
    logic [1:0]                        cluster_size;
    logic signed [sce_pkg::SUM_W-1:0]  counts_above;
    logic [sce_pkg::Q_W-1:0]           charge_center;
    logic                              center_invalid;

    modport source (output valid, eta_value, eta_counts, eta_sn, eta_invalid, cluster_size,
                    counts_above, charge_center, center_invalid, input ready);
    modport sink (input valid, eta_value, eta_counts, eta_sn, eta_invalid, cluster_size,
                  counts_above, charge_center, center_invalid, output ready);
endinterface

interface sce_cfg_if;
    logic                               valid;
    logic                               ready;
    logic [sce_pkg::CFG_IDX_W-1:0]      index;
    logic [sce_pkg::CFG_DATA_W-1:0]     data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

// ===== rtl/sce_div.sv =====
// Pipelined restoring divider, one quotient bit per stage.
`timescale 1ns / 1ps
`default_nettype none
module sce_div (
    input  logic                          clk,
    input  logic                          en,
    input  logic [sce_pkg::DIV_NW-1:0]    dividend,
    input  logic [sce_pkg::DIV_DW-1:0]    divisor,
    output logic [sce_pkg::DIV_QW-1:0]    quotient
);
    localparam int QW = sce_pkg::DIV_QW;
    localparam int DW = sce_pkg::DIV_DW;
    localparam int NW = sce_pkg::DIV_NW;

    logic [DW-1:0] rem_reg [QW];
    logic [QW-1:0] dq_reg  [QW];
    logic [DW-1:0] d_reg   [QW];

    for (genvar j = 0; j < QW; j++) begin : g_step
        logic [DW-1:0] rem_in;
        logic [DW-1:0] d_in;
        logic [QW-1:0] dq_in;
        logic [DW:0]   trial;
        logic [DW+1:0] diff;
        logic          ge;

        if (j == 0) begin : g_first
            assign rem_in = {{(DW - (NW - QW)){1'b0}}, dividend[NW-1:QW]};
            assign dq_in  = dividend[QW-1:0];
            assign d_in   = divisor;
        end else begin : g_next
            assign rem_in = rem_reg[j-1];
            assign dq_in  = dq_reg[j-1];
            assign d_in   = d_reg[j-1];
        end

        assign trial = {rem_in, dq_in[QW-1]};
        assign diff  = {1'b0, trial} - {2'b00, d_in};
        assign ge    = ~diff[DW+1];

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[j] <= ge ? diff[DW-1:0] : trial[DW-1:0];
                dq_reg[j]  <= {dq_in[QW-2:0], ge};
                d_reg[j]   <= d_in;
            end
        end
    end

    assign quotient = dq_reg[QW-1];
endmodule
`default_nettype wire

// ===== rtl/sce_lane.sv =====
// One strip lane: absent and zero-sigma handling, threshold test, S/N quotient.
`timescale 1ns / 1ps
`default_nettype none
module sce_lane (
    input  logic                                clk,
    input  logic                                en,
    input  logic                                present,
    input  logic signed [sce_pkg::CNT_W-1:0]    count,
    input  logic [sce_pkg::SIG_W-1:0]           sigma,
    input  logic [sce_pkg::THR_W-1:0]           thr,
    output sce_pkg::sce_lane_t                  info,
    output logic signed [sce_pkg::SNQ_W-1:0]    snq
);
    localparam int QW = sce_pkg::DIV_QW;

    logic signed [sce_pkg::CNT_W-1:0] c;
    logic [sce_pkg::SIG_W-1:0]        s;
    logic signed [sce_pkg::CNT_W-1:0] snc;
    logic [sce_pkg::SIG_W-1:0]        sns;
    logic signed [27:0]               lhs;
    logic [31:0]                      rhs;
    logic [sce_pkg::CNT_W-1:0]        mag;
    logic [QW-1:0]                    q;

    sce_pkg::sce_lane_t                 info_reg;
    logic [sce_pkg::DIV_NW-1:0]         dvd_reg;
    logic [sce_pkg::DIV_DW-1:0]         dsr_reg;
    // Sign travels with the operand register and the divider stages.
    logic [QW:0]                        neg_reg;

    always_comb
    begin
        c   = present ? count : '0;
        s   = present ? sigma : '0;
        snc = (s == '0) ? '0 : c;
        sns = (s == '0) ? sce_pkg::SIG_W'(1) : s;
        lhs = {snc, 12'd0};
        rhs = thr * sns;
        mag = snc[sce_pkg::CNT_W-1] ? sce_pkg::CNT_W'(-snc) : sce_pkg::CNT_W'(snc);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            info_reg.cnt   <= c;
            info_reg.snc   <= snc;
            info_reg.sns   <= sns;
            info_reg.above <= ($signed({{6{lhs[27]}}, lhs}) > $signed({2'b00, rhs}));
            dvd_reg        <= sce_pkg::DIV_NW'({mag, 12'd0});
            dsr_reg        <= sce_pkg::DIV_DW'(sns);
            neg_reg        <= {neg_reg[QW-1:0], snc[sce_pkg::CNT_W-1]};
        end
    end

    sce_div u_div (
        .clk      (clk),
        .en       (en),
        .dividend (dvd_reg),
        .divisor  (dsr_reg),
        .quotient (q)
    );

    assign info = info_reg;
    assign snq  = neg_reg[QW] ? -$signed({1'b0, q}) : $signed({1'b0, q});
endmodule
`default_nettype wire

// ===== rtl/strip_cluster_eta_top.sv =====
// Top level of the three-strip cluster eta and charge centre block.
//
// Channels: "cluster" takes one three-strip cluster per transfer, "result"
// gives one result per cluster in the same order, "cfg" writes the S/N
// threshold (index 0) and the eta mode (index 1); cfg is always ready.
// Throughput: one cluster per cycle. The datapath is a single pipeline with
// one enable, so a cluster enters on every cycle in which the result
// register is empty or being taken.
// Stages from the input transfer to the valid result:
// one lane stage, two merge stages, 28 stages of the pipelined restoring
// dividers (one quotient bit per stage) and the result register.
// Three lanes run side by side, one per strip, each with its own S/N
// divider; the merge stages pick the eta partner and form the sums, and two
// more dividers give eta and the charge centre.
// Reset: the pipeline empties, the threshold returns to 3.0 and the mode
// to two-strip eta.
// Stall: while result is valid and not taken the whole pipeline holds and
// cluster.ready drops; nothing in flight is lost.
`timescale 1ns / 1ps
`default_nettype none
module strip_cluster_eta_top (
    input  logic         clk,
    input  logic         rst_n,
    sce_cluster_if.sink  cluster,
    sce_result_if.source result,
    sce_cfg_if.sink      cfg
);
    localparam int SUM_W = sce_pkg::SUM_W;
    localparam int QW    = sce_pkg::DIV_QW;

    // Pipeline enable: advance whenever the result register can move.
    logic en;
    logic out_valid_reg;

    assign en            = ~out_valid_reg | result.ready;
    assign cluster.ready = en;
    assign cfg.ready     = 1'b1;

    // Configuration registers.
    logic [sce_pkg::THR_W-1:0] thr_reg;
    logic                      mode_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg  <= sce_pkg::THR_RESET;
            mode_reg <= 1'b0;
        end
        else if (cfg.valid)
        begin
            case (cfg.index)
                sce_pkg::REG_SIDE_THRESHOLD: thr_reg  <= cfg.data;
                sce_pkg::REG_ETA_MODE:       mode_reg <= cfg.data[0];
                default: ;
            endcase
        end
    end

    // Valid shift line along the pipeline.
    logic [sce_pkg::PIPE_DEPTH-1:0] v_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg         <= '0;
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            v_reg         <= {v_reg[sce_pkg::PIPE_DEPTH-2:0], cluster.valid};
            out_valid_reg <= v_reg[sce_pkg::PIPE_DEPTH-1];
        end
    end

    // Ladder edges; a channel past the ladder end counts as the last strip.
    logic at_left;
    logic at_right;

    assign at_left  = (cluster.ladder_channel == '0);
    assign at_right = (cluster.ladder_channel >= sce_pkg::CH_LAST);

    // Lanes: left, seed, right.
    sce_pkg::sce_lane_t               info [3];
    logic signed [sce_pkg::SNQ_W-1:0] snq  [3];

    sce_lane u_lane_left (
        .clk(clk), .en(en), .present(~at_left), .count(cluster.count_left),
        .sigma(cluster.sigma_left), .thr(thr_reg), .info(info[0]), .snq(snq[0])
    );
    sce_lane u_lane_seed (
        .clk(clk), .en(en), .present(1'b1), .count(cluster.count_seed),
        .sigma(cluster.sigma_seed), .thr(thr_reg), .info(info[1]), .snq(snq[1])
    );
    sce_lane u_lane_right (
        .clk(clk), .en(en), .present(~at_right), .count(cluster.count_right),
        .sigma(cluster.sigma_right), .thr(thr_reg), .info(info[2]), .snq(snq[2])
    );

    // Stage 1 side data: edges and mode travel with the lane registers.
    logic at_left_s1_reg;
    logic at_right_s1_reg;
    logic mode_s1_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            at_left_s1_reg  <= at_left;
            at_right_s1_reg <= at_right;
            mode_s1_reg     <= mode_reg;
        end
    end

    // Stage 2: neighbour S/N cross products, threshold sums.
    logic signed [32:0]      prod_l_next;
    logic signed [32:0]      prod_r_next;
    logic signed [SUM_W-1:0] above_sum_next;
    logic signed [SUM_W-1:0] wsum_next;
    logic [1:0]              size_next;

    logic signed [32:0]             prod_l_reg;
    logic signed [32:0]             prod_r_reg;
    logic signed [SUM_W-1:0]        above_sum_reg;
    logic signed [SUM_W-1:0]        wsum_reg;
    logic [1:0]                     size_reg;
    logic signed [sce_pkg::CNT_W-1:0] cnt_reg [3];
    logic at_left_s2_reg;
    logic at_right_s2_reg;
    logic mode_s2_reg;

    always_comb
    begin
        prod_l_next = $signed(info[0].snc) * $signed({1'b0, info[2].sns});
        prod_r_next = $signed(info[2].snc) * $signed({1'b0, info[0].sns});
        above_sum_next = (info[0].above ? SUM_W'(info[0].cnt) : '0)
                       + (info[1].above ? SUM_W'(info[1].cnt) : '0)
                       + (info[2].above ? SUM_W'(info[2].cnt) : '0);
        wsum_next = (info[1].above ? SUM_W'(info[1].cnt) : '0)
                  + (info[2].above ? (SUM_W'(info[2].cnt) <<< 1) : '0);
        size_next = 2'(info[0].above) + 2'(info[1].above) + 2'(info[2].above);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            prod_l_reg      <= prod_l_next;
            prod_r_reg      <= prod_r_next;
            above_sum_reg   <= above_sum_next;
            wsum_reg        <= wsum_next;
            size_reg        <= size_next;
            cnt_reg[0]      <= info[0].cnt;
            cnt_reg[1]      <= info[1].cnt;
            cnt_reg[2]      <= info[2].cnt;
            at_left_s2_reg  <= at_left_s1_reg;
            at_right_s2_reg <= at_right_s1_reg;
            mode_s2_reg     <= mode_s1_reg;
        end
    end

    // Stage 3: partner choice, eta numerator and denominator, divider operands.
    logic                    partner_left;
    logic signed [SUM_W-1:0] num;
    logic signed [SUM_W-1:0] den;
    sce_pkg::sce_side_t      side_next;

    logic [sce_pkg::DIV_NW-1:0] eta_dvd_reg;
    logic [sce_pkg::DIV_DW-1:0] eta_dsr_reg;
    logic [sce_pkg::DIV_NW-1:0] ctr_dvd_reg;
    logic [sce_pkg::DIV_DW-1:0] ctr_dsr_reg;
    sce_pkg::sce_side_t         side_reg [QW+1];

    always_comb
    begin
        // Tie on neighbour S/N goes to the right strip.
        if (at_left_s2_reg)
            partner_left = 1'b0;
        else if (at_right_s2_reg)
            partner_left = 1'b1;
        else
            partner_left = (prod_l_reg > prod_r_reg);

        if (mode_s2_reg)
        begin
            den = SUM_W'(cnt_reg[0]) + SUM_W'(cnt_reg[1]) + SUM_W'(cnt_reg[2]);
            num = SUM_W'(cnt_reg[1]) + (SUM_W'(cnt_reg[2]) <<< 1);
        end
        else
        begin
            den = SUM_W'(cnt_reg[1]) + (partner_left ? SUM_W'(cnt_reg[0])
                                                      : SUM_W'(cnt_reg[2]));
            num = partner_left ? SUM_W'(cnt_reg[1]) : SUM_W'(cnt_reg[2]);
        end

        side_next.mode         = mode_s2_reg;
        side_next.partner_left = partner_left;
        side_next.den          = den;
        side_next.eta_ok       = (num > 0) && (den > 0);
        // Quotient of at least four saturates; this also keeps the divider in range.
        side_next.eta_sat      = ($signed(20'(num)) >= $signed({den, 2'b00}));
        side_next.size         = size_reg;
        side_next.above_sum    = above_sum_reg;
        side_next.ctr_ok       = (wsum_reg > 0) && (above_sum_reg > 0);
        side_next.ctr_sat      = ($signed(20'(wsum_reg)) >= $signed({above_sum_reg, 2'b00}));
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            eta_dvd_reg <= sce_pkg::DIV_NW'({num[16:0], 16'd0});
            eta_dsr_reg <= den;
            ctr_dvd_reg <= sce_pkg::DIV_NW'({wsum_reg[16:0], 16'd0});
            ctr_dsr_reg <= above_sum_reg;
            side_reg[0] <= side_next;
            for (int k = 1; k <= QW; k++)
                side_reg[k] <= side_reg[k-1];
        end
    end

    logic [QW-1:0] eta_q;
    logic [QW-1:0] ctr_q;

    sce_div u_div_eta (
        .clk(clk), .en(en), .dividend(eta_dvd_reg), .divisor(eta_dsr_reg), .quotient(eta_q)
    );
    sce_div u_div_ctr (
        .clk(clk), .en(en), .dividend(ctr_dvd_reg), .divisor(ctr_dsr_reg), .quotient(ctr_q)
    );

    // Lane S/N results come out two stages early; hold them two more.
    logic signed [sce_pkg::SNQ_W-1:0] snq_d1_reg [3];
    logic signed [sce_pkg::SNQ_W-1:0] snq_d2_reg [3];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k < 3; k++)
            begin
                snq_d1_reg[k] <= snq[k];
                snq_d2_reg[k] <= snq_d1_reg[k];
            end
        end
    end

    // Final merge into the result register.
    sce_pkg::sce_side_t                 sd;
    logic signed [sce_pkg::SNS_W-1:0]   snsum;
    logic signed [sce_pkg::SN_W-1:0]    sn_next;
    logic [sce_pkg::Q_W-1:0]            eta_next;
    logic [sce_pkg::Q_W-1:0]            ctr_next;

    logic [sce_pkg::Q_W-1:0]            eta_value_reg;
    logic signed [SUM_W-1:0]            eta_counts_reg;
    logic signed [sce_pkg::SN_W-1:0]    eta_sn_reg;
    logic                               eta_invalid_reg;
    logic [1:0]                         cluster_size_reg;
    logic signed [SUM_W-1:0]            counts_above_reg;
    logic [sce_pkg::Q_W-1:0]            charge_center_reg;
    logic                               center_invalid_reg;

    always_comb
    begin
        sd = side_reg[QW];
        if (sd.mode)
            snsum = sce_pkg::SNS_W'(snq_d2_reg[0]) + sce_pkg::SNS_W'(snq_d2_reg[1])
                  + sce_pkg::SNS_W'(snq_d2_reg[2]);
        else
            snsum = sce_pkg::SNS_W'(snq_d2_reg[1])
                  + (sd.partner_left ? sce_pkg::SNS_W'(snq_d2_reg[0])
                                     : sce_pkg::SNS_W'(snq_d2_reg[2]));

        if (snsum > sce_pkg::SNS_W'(sce_pkg::SN_MAX))
            sn_next = sce_pkg::SN_MAX;
        else if (snsum < sce_pkg::SNS_W'(sce_pkg::SN_MIN))
            sn_next = sce_pkg::SN_MIN;
        else
            sn_next = snsum[sce_pkg::SN_W-1:0];

        if (!sd.eta_ok)
            eta_next = '0;
        else if (sd.eta_sat || (eta_q > QW'(sce_pkg::Q16_MAX)))
            eta_next = sce_pkg::Q16_MAX;
        else
            eta_next = eta_q[sce_pkg::Q_W-1:0];

        if (!sd.ctr_ok)
            ctr_next = '0;
        else if (sd.ctr_sat || (ctr_q > QW'(sce_pkg::Q16_MAX)))
            ctr_next = sce_pkg::Q16_MAX;
        else
            ctr_next = ctr_q[sce_pkg::Q_W-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            eta_value_reg      <= eta_next;
            eta_counts_reg     <= sd.den;
            eta_sn_reg         <= sn_next;
            eta_invalid_reg    <= ~(sd.den > 0);
            cluster_size_reg   <= sd.size;
            counts_above_reg   <= sd.above_sum;
            charge_center_reg  <= ctr_next;
            center_invalid_reg <= ~(sd.above_sum > 0);
        end
    end

    assign result.valid          = out_valid_reg;
    assign result.eta_value      = eta_value_reg;
    assign result.eta_counts     = eta_counts_reg;
    assign result.eta_sn         = eta_sn_reg;
    assign result.eta_invalid    = eta_invalid_reg;
    assign result.cluster_size   = cluster_size_reg;
    assign result.counts_above   = counts_above_reg;
    assign result.charge_center  = charge_center_reg;
    assign result.center_invalid = center_invalid_reg;
endmodule
`default_nettype wire

// ===== rtl/sce_checker.sv =====
// Port-level checker for the strip cluster eta block, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
module sce_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_ready,
    input logic        out_valid,
    input logic        out_ready,
    input logic [17:0] eta_value,
    input logic        eta_invalid,
    input logic [1:0]  cluster_size,
    input logic [17:0] counts_above,
    input logic [17:0] charge_center,
    input logic        center_invalid
);
    a_stall_only: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> (out_valid && !out_ready))
        else $error("input stalled without a blocked result");

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> out_valid)
        else $error("result dropped while stalled");

    a_eta_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && eta_invalid) |-> (eta_value == 18'd0))
        else $error("invalid eta with nonzero value");

    a_center_flag: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (center_invalid == ($signed(counts_above) <= 0))
                      && (!center_invalid || charge_center == 18'd0))
        else $error("center flag disagrees with summed counts");

    a_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && cluster_size == 2'd0) |-> (counts_above == 18'd0))
        else $error("empty cluster with nonzero counts");
endmodule

bind strip_cluster_eta_top sce_checker u_sce_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_ready       (cluster.ready),
    .out_valid      (result.valid),
    .out_ready      (result.ready),
    .eta_value      (result.eta_value),
    .eta_invalid    (result.eta_invalid),
    .cluster_size   (result.cluster_size),
    .counts_above   (result.counts_above),
    .charge_center  (result.charge_center),
    .center_invalid (result.center_invalid)
);
`default_nettype wire

// ===== sim/strip_cluster_eta_top_tb.sv =====
// Self-checking testbench of the strip cluster eta block: directed table, then random.
`timescale 1ns / 1ps
`default_nettype none
module strip_cluster_eta_top_tb;

    // One cluster as the sender offers it, plus the hand-typed result where known.
    typedef struct {
        logic [sce_pkg::CH_W-1:0]         ch;
        logic signed [sce_pkg::CNT_W-1:0] cl, cs, cr;
        logic [sce_pkg::SIG_W-1:0]        gl, gs, gr;
    } cluster_t;

    typedef struct {
        logic [sce_pkg::Q_W-1:0]          eta;
        logic signed [sce_pkg::SUM_W-1:0] eta_cnt;
        logic signed [sce_pkg::SN_W-1:0]  sn;
        logic                             eta_bad;
        logic [1:0]                       size;
        logic signed [sce_pkg::SUM_W-1:0] above;
        logic [sce_pkg::Q_W-1:0]          ctr;
        logic                             ctr_bad;
    } eta_result_t;

    typedef struct {
        cluster_t    c;
        logic        typed;
        eta_result_t r;
    } table_row_t;

    localparam int WATCHDOG   = 20000;
    localparam int N_RANDOM   = 400;
    localparam int DRAIN_WAIT = 64;

    logic clk;
    logic rst_n;

    sce_cluster_if cluster ();
    sce_result_if  result ();
    sce_cfg_if     cfg ();

    strip_cluster_eta_top uut (
        .clk     (clk),
        .rst_n   (rst_n),
        .cluster (cluster.sink),
        .result  (result.source),
        .cfg     (cfg.sink)
    );

    // Shadow copy of the configuration registers.
    logic [sce_pkg::THR_W-1:0] thr_shadow;
    logic                      mode_shadow;

    eta_result_t expected_q[$];
    int          mismatches  = 0;
    int          idle_cycles = 0;
    bit          timed_out   = 1'b0;
    bit          hold_off;

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // Q2.16 quotient, truncated, saturated to 0..2.0.
    function automatic logic [sce_pkg::Q_W-1:0] q16_div(longint num, longint den);
        longint q;
        if (num <= 0 || den <= 0)
            return '0;
        q = (num * 65536) / den;
        if (q > 131072)
            q = 131072;
        return sce_pkg::Q_W'(q);
    endfunction

    function automatic eta_result_t predict_eta(cluster_t c);
        eta_result_t r;
        longint cnt[3], snc[3], sns[3], snq[3];
        longint cin[3], sin[3];
        bit     present[3];
        longint ch, num, den, snsum, above, wsum;
        int     size, partner;
        ch = c.ch;
        if (ch > sce_pkg::LADDER_CHANNELS - 1)
            ch = sce_pkg::LADDER_CHANNELS - 1;
        present[0] = (ch != 0);
        present[1] = 1'b1;
        present[2] = (ch != sce_pkg::LADDER_CHANNELS - 1);
        cin[0] = c.cl; cin[1] = c.cs; cin[2] = c.cr;
        sin[0] = c.gl; sin[1] = c.gs; sin[2] = c.gr;
        above = 0;
        wsum = 0;
        size = 0;
        for (int i = 0; i < 3; i++)
        begin
            if (!present[i])
            begin
                cin[i] = 0;
                sin[i] = 0;
            end
            cnt[i] = cin[i];
            // Zero sigma: no S/N, but the raw count still feeds eta.
            snc[i] = (sin[i] == 0) ? 0 : cin[i];
            sns[i] = (sin[i] == 0) ? 1 : sin[i];
            snq[i] = (snc[i] * 4096) / sns[i];
            if (snc[i] * 4096 > longint'(thr_shadow) * sns[i])
            begin
                size++;
                above += cnt[i];
                wsum += i * cnt[i];
            end
        end
        if (!mode_shadow)
        begin
            if (ch == 0)
                partner = 2;
            else if (ch == sce_pkg::LADDER_CHANNELS - 1)
                partner = 0;
            else
                partner = (snc[0] * sns[2] > snc[2] * sns[0]) ? 0 : 2;
            den = cnt[1] + cnt[partner];
            num = (partner == 2) ? cnt[2] : cnt[1];
            snsum = snq[1] + snq[partner];
        end
        else
        begin
            den = cnt[0] + cnt[1] + cnt[2];
            num = cnt[1] + 2 * cnt[2];
            snsum = snq[0] + snq[1] + snq[2];
        end
        if (snsum > 8388607)
            snsum = 8388607;
        if (snsum < -8388608)
            snsum = -8388608;
        r.eta     = q16_div(num, den);
        r.eta_cnt = sce_pkg::SUM_W'(den);
        r.sn      = sce_pkg::SN_W'(snsum);
        r.eta_bad = (den <= 0);
        r.size    = 2'(size);
        r.above   = sce_pkg::SUM_W'(above);
        r.ctr     = q16_div(wsum, above);
        r.ctr_bad = (above <= 0);
        return r;
    endfunction

    function automatic cluster_t random_cluster();
        cluster_t c;
        int pick;
        pick = $urandom_range(0, 9);
        // Bias toward ladder edges and out-of-range channels.
        case (pick)
            0: c.ch = '0;
            1: c.ch = sce_pkg::CH_LAST;
            2: c.ch = sce_pkg::CH_W'($urandom_range(sce_pkg::LADDER_CHANNELS, 511));
            default: c.ch = sce_pkg::CH_W'($urandom_range(1, sce_pkg::LADDER_CHANNELS - 2));
        endcase
        if ($urandom_range(0, 3) == 0)
        begin
            c.cl = sce_pkg::CNT_W'($urandom);
            c.cs = sce_pkg::CNT_W'($urandom);
            c.cr = sce_pkg::CNT_W'($urandom);
        end
        else
        begin
            // Realistic cluster: seed large, neighbours smaller, some noise.
            c.cs = sce_pkg::CNT_W'($urandom_range(0, 4000));
            c.cl = sce_pkg::CNT_W'(int'($urandom_range(0, 1200)) - 200);
            c.cr = sce_pkg::CNT_W'(int'($urandom_range(0, 1200)) - 200);
        end
        if ($urandom_range(0, 3) == 0)
        begin
            c.gl = sce_pkg::SIG_W'($urandom);
            c.gs = sce_pkg::SIG_W'($urandom);
            c.gr = sce_pkg::SIG_W'($urandom);
        end
        else
        begin
            c.gl = sce_pkg::SIG_W'($urandom_range(0, 800));
            c.gs = sce_pkg::SIG_W'($urandom_range(1, 800));
            c.gr = sce_pkg::SIG_W'($urandom_range(0, 800));
        end
        return c;
    endfunction

    // Drive one cluster and hold it until the transfer completes; valid stays
    // high afterwards so back-to-back clusters need no gap.
    task automatic send_cluster(cluster_t c, logic typed, eta_result_t r);
        int gap;
        gap = ($urandom_range(0, 2) == 0) ? $urandom_range(0, 18) : 0;
        if (gap != 0)
        begin
            cluster.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        cluster.valid          <= 1'b1;
        cluster.ladder_channel <= c.ch;
        cluster.count_left     <= c.cl;
        cluster.count_seed     <= c.cs;
        cluster.count_right    <= c.cr;
        cluster.sigma_left     <= c.gl;
        cluster.sigma_seed     <= c.gs;
        cluster.sigma_right    <= c.gr;
        do
            @(posedge clk);
        while (!cluster.ready);
        // Push the expectation at the transfer edge, before any result can land.
        expected_q.push_back(typed ? r : predict_eta(c));
    endtask

    task automatic write_reg(logic [sce_pkg::CFG_IDX_W-1:0] idx,
                             logic [sce_pkg::CFG_DATA_W-1:0] value);
        cfg.valid <= 1'b1;
        cfg.index <= idx;
        cfg.data  <= value;
        do
            @(posedge clk);
        while (!cfg.ready);
        cfg.valid <= 1'b0;
        if (idx == sce_pkg::REG_SIDE_THRESHOLD)
            thr_shadow = value;
        else
            mode_shadow = value[0];
        @(posedge clk);
    endtask

    // Drop valid, wait until every expected result is back, then let the pipeline settle.
    task automatic wait_drained();
        cluster.valid <= 1'b0;
        while (expected_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);
    endtask

    task automatic run_random(int n);
        eta_result_t none;
        none = '{default: '0};
        for (int i = 0; i < n; i++)
            send_cluster(random_cluster(), 1'b0, none);
    endtask

    // Receiver: random stalls per result, plus a long hold-off when asked.
    initial
    begin
        int stall;
        result.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            if (hold_off)
            begin
                result.ready <= 1'b0;
                @(posedge clk);
            end
            else
            begin
                stall = ($urandom_range(0, 2) == 0) ? $urandom_range(0, 18) : 0;
                if (stall != 0)
                begin
                    result.ready <= 1'b0;
                    repeat (stall) @(posedge clk);
                end
                result.ready <= 1'b1;
                @(posedge clk);
            end
        end
    end

    // Compare each result transfer with the oldest expectation.
    always @(posedge clk)
    begin
        eta_result_t e;
        if (rst_n && result.valid && result.ready)
        begin
            if (expected_q.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result at %0t", $realtime);
            end
            else
            begin
                e = expected_q.pop_front();
                if (result.eta_value !== e.eta || result.eta_counts !== e.eta_cnt
                    || result.eta_sn !== e.sn || result.eta_invalid !== e.eta_bad
                    || result.cluster_size !== e.size || result.counts_above !== e.above
                    || result.charge_center !== e.ctr
                    || result.center_invalid !== e.ctr_bad)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch at %0t: exp eta=%0d cnt=%0d sn=%0d bad=%0b ",
                                 $realtime, e.eta, e.eta_cnt, e.sn, e.eta_bad,
                                 "size=%0d above=%0d ctr=%0d cbad=%0b | got %0d %0d %0d ",
                                 e.size, e.above, e.ctr, e.ctr_bad, result.eta_value,
                                 result.eta_counts, result.eta_sn,
                                 "%0b %0d %0d %0d %0b", result.eta_invalid,
                                 result.cluster_size, result.counts_above,
                                 result.charge_center, result.center_invalid);
                end
            end
        end
    end

    // Watchdog: count cycles with no transfer on any channel.
    always @(posedge clk)
    begin
        if ((cluster.valid && cluster.ready) || (result.valid && result.ready)
            || (cfg.valid && cfg.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
    end

    initial
    begin
        wait (idle_cycles >= WATCHDOG);
        timed_out = 1'b1;
        $display("status: fail");
        $finish;
    end

    initial
    begin
        table_row_t rows[$];
        eta_result_t none;
        none = '{default: '0};
        hold_off    = 1'b0;
        thr_shadow  = sce_pkg::THR_RESET;
        mode_shadow = 1'b0;
        rst_n = 1'b0;
        cluster.valid = 1'b0;
        cluster.ladder_channel = '0;
        cluster.count_left = '0;
        cluster.count_seed = '0;
        cluster.count_right = '0;
        cluster.sigma_left = '0;
        cluster.sigma_seed = '0;
        cluster.sigma_right = '0;
        cfg.valid = 1'b0;
        cfg.index = sce_pkg::REG_SIDE_THRESHOLD;
        cfg.data  = '0;

        // Directed table; typed rows hold results that are plain to see.
        // All-zero cluster: both denominators zero, both flagged invalid.
        rows.push_back('{'{9'd10, 16'sd0, 16'sd0, 16'sd0, 16'd1, 16'd1, 16'd1}, 1'b1,
                         '{18'd0, 18'sd0, 24'sd0, 1'b1, 2'd0, 18'sd0, 18'd0, 1'b1}});
        // Seed only, sigma 1.0: S/N 100 above 3.0, eta 0, centre 1.0.
        rows.push_back('{'{9'd10, 16'sd0, 16'sd100, 16'sd0, 16'd16, 16'd16, 16'd16}, 1'b1,
                         '{18'd0, 18'sd100, 24'sd25600, 1'b0, 2'd1, 18'sd100, 18'd65536,
                           1'b0}});
        // Right neighbour larger than the left: right partner, eta 0.5.
        rows.push_back('{'{9'd10, 16'sd50, 16'sd100, 16'sd100, 16'd16, 16'd16, 16'd16},
                         1'b0, none});
        // Left edge, right edge, beyond the ladder.
        rows.push_back('{'{9'd0, 16'sd900, 16'sd100, 16'sd40, 16'd16, 16'd16, 16'd16},
                         1'b0, none});
        rows.push_back('{'{sce_pkg::CH_LAST, 16'sd40, 16'sd100, 16'sd900,
                           16'd16, 16'd16, 16'd16}, 1'b0, none});
        rows.push_back('{'{9'd511, 16'sd40, 16'sd100, 16'sd900, 16'd16, 16'd16, 16'd16},
                         1'b0, none});
        // Zero sigma on each strip.
        rows.push_back('{'{9'd5, 16'sd300, 16'sd100, 16'sd20, 16'd0, 16'd16, 16'd16},
                         1'b0, none});
        rows.push_back('{'{9'd5, 16'sd30, 16'sd100, 16'sd20, 16'd16, 16'd0, 16'd16},
                         1'b0, none});
        rows.push_back('{'{9'd5, 16'sd30, 16'sd100, 16'sd200, 16'd16, 16'd16, 16'd0},
                         1'b0, none});
        // Count extremes with tiny sigma: S/N saturation.
        rows.push_back('{'{9'd7, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'd1, 16'd1, 16'd1},
                         1'b0, none});
        rows.push_back('{'{9'd7, -16'sd32768, -16'sd32768, -16'sd32768, 16'd1, 16'd1, 16'd1},
                         1'b0, none});
        // Mixed signs: in three-strip mode the first row gives a negative eta, which goes to zero.
        rows.push_back('{'{9'd7, 16'sd2000, 16'sd500, -16'sd400, 16'd16, 16'd16, 16'd16},
                         1'b0, none});
        rows.push_back('{'{9'd7, -16'sd300, 16'sd100, 16'sd900, 16'd16, 16'd16, 16'd16},
                         1'b0, none});
        // Sigma extremes.
        rows.push_back('{'{9'd200, 16'sd1000, 16'sd2000, 16'sd500,
                           16'hFFFF, 16'hFFFF, 16'hFFFF}, 1'b0, none});
        rows.push_back('{'{9'd1, 16'sd5, 16'sd1, 16'sd3, 16'd1, 16'd1, 16'd1}, 1'b0, none});
        rows.push_back('{'{9'd382, 16'sh5555, -16'sd21846, 16'sh5555,
                           16'h5555, 16'hAAAA, 16'h0F0F}, 1'b0, none});

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Phase 1: reset settings, directed rows.
        foreach (rows[i])
            send_cluster(rows[i].c, rows[i].typed, rows[i].r);
        wait_drained();

        // Phase 2: three-strip mode, same rows through the predictor.
        write_reg(sce_pkg::REG_ETA_MODE, 16'd1);
        foreach (rows[i])
            send_cluster(rows[i].c, 1'b0, none);
        wait_drained();

        // Phase 3: threshold zero, random clusters, three-strip mode.
        write_reg(sce_pkg::REG_SIDE_THRESHOLD, 16'd0);
        run_random(100);

        // Long hold-off on the result side while clusters keep coming.
        hold_off = 1'b1;
        fork
            run_random(60);
            begin
                repeat (200) @(posedge clk);
                hold_off = 1'b0;
            end
        join
        wait_drained();

        // Phase 4: threshold max, two-strip mode.
        write_reg(sce_pkg::REG_SIDE_THRESHOLD, 16'hFFFF);
        write_reg(sce_pkg::REG_ETA_MODE, 16'd0);
        run_random(100);
        wait_drained();

        // Phase 5: random threshold in two-strip mode, then threshold 0x8000 in three-strip mode.
        write_reg(sce_pkg::REG_SIDE_THRESHOLD,
                  sce_pkg::CFG_DATA_W'($urandom_range(0, 4096)));
        run_random(70);
        wait_drained();
        write_reg(sce_pkg::REG_ETA_MODE, 16'd1);
        write_reg(sce_pkg::REG_SIDE_THRESHOLD, 16'h8000);
        run_random(70);
        wait_drained();

        if (mismatches == 0 && expected_q.size() == 0 && !timed_out)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end
endmodule
`default_nettype wire
